// File: rtl/core/mss_pkg.sv
// Shared types, codes and defaults for the min-tracking stack.
package mss_pkg;

   localparam int DefStackDepth = 256;
   localparam int DefValueWidth = 32;

   localparam int PortValueWidth = 32;
   localparam int OccupancyWidth = 9;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE     = 1'b0,
      S_POP_LOAD = 1'b1
   } state_type;

endpackage

// File: rtl/core/min_stack_two_stack_top.sv
// Top level: bounded signed stack with running minimum via a stack of minima.
//
// Usage:
//   Issue a word by raising start with req_type (0 push, 1 pop) and
//   req_push_value while busy is low; the word is taken at that clock edge.
//   Each word produces exactly one result word, flagged by rsp_valid for a
//   single cycle: top value, minimum, occupancy and status after the word.
//   Top and minimum read zero while the stack is empty.
// Word flow:
//   Push, overflowing push and underflowing pop: result in the cycle after
//   the accepting edge; the next word may follow immediately.
//   Successful pop: busy while the new tops are read from the value and
//   minima memories through their registered read ports; the result is
//   registered from the pop-load state, and no new word is taken in that state.
//   Both stack tops are held in registers; the memories hold every entry.
// Reset:
//   Synchronous, active high; clears both counts and the controller. Memory
//   contents are not cleared and need no clearing pass.
// Output flow:
//   The receiver cannot stall; every result is presented for one cycle only.
module min_stack_two_stack_top #(
   parameter int STACK_DEPTH = mss_pkg::DefStackDepth,
   parameter int VALUE_WIDTH = mss_pkg::DefValueWidth
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         start,
   output logic                                         busy,
   input  logic                                         req_type,
   input  logic signed [mss_pkg::PortValueWidth-1:0]    req_push_value,
   output logic                                         rsp_valid,
   output logic signed [mss_pkg::PortValueWidth-1:0]    rsp_top_value,
   output logic signed [mss_pkg::PortValueWidth-1:0]    rsp_min_value,
   output logic [mss_pkg::OccupancyWidth-1:0]           rsp_occupancy,
   output logic [1:0]                                   rsp_status
);

   import mss_pkg::*;

   localparam int AddrWidth  = $clog2(STACK_DEPTH);
   localparam int CountWidth = $clog2(STACK_DEPTH + 1);

   state_type state_ff, state_in;

   logic [CountWidth-1:0]         count_ff, count_in;
   logic [CountWidth-1:0]         mcount_ff, mcount_in;
   logic signed [VALUE_WIDTH-1:0] top_ff, top_in;
   logic signed [VALUE_WIDTH-1:0] mtop_ff, mtop_in;
   status_type                    status_ff, status_in;
   logic                          valid_ff, valid_in;
   logic                          min_pop_ff, min_pop_in;

   logic                          accept;
   logic signed [VALUE_WIDTH-1:0] push_v;
   logic                          full;
   logic                          empty;
   logic                          min_push;
   logic                          min_pop;
   logic [CountWidth-1:0]         pop_count;
   logic [CountWidth-1:0]         pop_mcount;

   logic                   val_we, min_we, rd_en;
   logic [AddrWidth-1:0]   val_waddr, min_waddr, val_raddr, min_raddr;
   logic [VALUE_WIDTH-1:0] val_rdata, min_rdata;

   assign accept     = start && !busy;
   assign push_v     = VALUE_WIDTH'(req_push_value);
   assign full       = count_ff >= CountWidth'(STACK_DEPTH);
   assign empty      = count_ff == '0;
   assign min_push   = (mcount_ff == '0) || (push_v <= mtop_ff);
   assign min_pop    = (mcount_ff != '0) && (mtop_ff == top_ff);
   assign pop_count  = count_ff - CountWidth'(1);
   assign pop_mcount = min_pop ? mcount_ff - CountWidth'(1) : mcount_ff;

   // memory access
   assign val_we    = accept && (op_type'(req_type) == OP_PUSH) && !full;
   assign min_we    = val_we && min_push;
   assign val_waddr = count_ff[AddrWidth-1:0];
   assign min_waddr = mcount_ff[AddrWidth-1:0];
   assign rd_en     = accept && (op_type'(req_type) == OP_POP) && !empty;
   assign val_raddr = AddrWidth'(pop_count - CountWidth'(1));
   assign min_raddr = AddrWidth'(pop_mcount - CountWidth'(1));

   mss_mem #(.DEPTH(STACK_DEPTH), .WIDTH(VALUE_WIDTH)) u_val_mem (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr),
      .wr_data (push_v),
      .rd_en   (rd_en),
      .rd_addr (val_raddr),
      .rd_data (val_rdata)
   );

   mss_mem #(.DEPTH(STACK_DEPTH), .WIDTH(VALUE_WIDTH)) u_min_mem (
      .clock   (clock),
      .wr_en   (min_we),
      .wr_addr (min_waddr),
      .wr_data (push_v),
      .rd_en   (rd_en),
      .rd_addr (min_raddr),
      .rd_data (min_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (rd_en) begin
               state_in = S_POP_LOAD;
            end
         end
         S_POP_LOAD: state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // controller outputs
   always_comb begin
      busy = 1'b0;
      unique case (state_ff)
         S_IDLE:     busy = 1'b0;
         S_POP_LOAD: busy = 1'b1;
         default:    busy = 1'b1;
      endcase
   end

   // datapath update
   always_comb begin
      count_in   = count_ff;
      mcount_in  = mcount_ff;
      top_in     = top_ff;
      mtop_in    = mtop_ff;
      status_in  = status_ff;
      valid_in   = 1'b0;
      min_pop_in = min_pop_ff;
      if (state_ff == S_POP_LOAD) begin
         valid_in = 1'b1;
         top_in   = val_rdata;
         if (min_pop_ff) begin
            mtop_in = min_rdata;
         end
      end else if (accept) begin
         if (op_type'(req_type) == OP_PUSH) begin
            valid_in = 1'b1;
            if (full) begin
               status_in = ST_OVERFLOW;
            end else begin
               status_in = ST_OK;
               count_in  = count_ff + CountWidth'(1);
               top_in    = push_v;
               if (min_push) begin
                  mcount_in = mcount_ff + CountWidth'(1);
                  mtop_in   = push_v;
               end
            end
         end else begin
            if (empty) begin
               valid_in  = 1'b1;
               status_in = ST_UNDERFLOW;
            end else begin
               status_in  = ST_OK;
               count_in   = pop_count;
               mcount_in  = pop_mcount;
               min_pop_in = min_pop;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         mcount_ff <= '0;
         valid_ff  <= 1'b0;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         mcount_ff <= mcount_in;
         valid_ff  <= valid_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff     <= top_in;
      mtop_ff    <= mtop_in;
      min_pop_ff <= min_pop_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_top_value = empty ? '0 : PortValueWidth'(top_ff);
   assign rsp_min_value = (empty || mcount_ff == '0) ? '0 : PortValueWidth'(mtop_ff);
   assign rsp_occupancy = OccupancyWidth'(count_ff);
   assign rsp_status    = status_ff;

endmodule

// File: rtl/core/mss_mem.sv
// Single-port-write, registered-read memory for one stack store.
module mss_mem #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: test/tb_min_stack_two_stack_top.sv
// Testbench for the min-tracking stack: push/pop words checked against a shadow stack.
`timescale 1ns / 100ps

module tb_min_stack_two_stack_top;
   import mss_pkg::*;

   localparam int Depth = mss_pkg::DefStackDepth;
   localparam int RandomWords = 110;

   typedef struct {
      logic signed [PortValueWidth-1:0] top;
      logic signed [PortValueWidth-1:0] min;
      logic [OccupancyWidth-1:0]        occupancy;
      status_type                       status;
   } stack_view_type;

   logic                               clock;
   logic                               reset;
   logic                               start;
   logic                               busy;
   logic                               req_type;
   logic signed [PortValueWidth-1:0]   req_push_value;
   logic                               rsp_valid;
   logic signed [PortValueWidth-1:0]   rsp_top_value;
   logic signed [PortValueWidth-1:0]   rsp_min_value;
   logic [OccupancyWidth-1:0]          rsp_occupancy;
   logic [1:0]                         rsp_status;

   logic signed [PortValueWidth-1:0]   shadow_values [Depth];
   logic signed [PortValueWidth-1:0]   shadow_minima [Depth];
   int                                 value_count;
   int                                 minima_count;
   stack_view_type                     expected_views [$];
   stack_view_type                     oldest_view;
   int                                 errors;
   bit                                 idling_on;

   min_stack_two_stack_top u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_top_value  (rsp_top_value),
      .rsp_min_value  (rsp_min_value),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Shadow stack: applies one word and returns the view after it.
   function automatic stack_view_type apply_stack_op(op_type op,
                                                     logic signed [PortValueWidth-1:0] value);
      stack_view_type view;
      view.status = ST_OK;
      if (op == OP_PUSH) begin
         if (value_count >= Depth) begin
            view.status = ST_OVERFLOW;
         end else begin
            shadow_values[value_count] = value;
            value_count++;
            if (minima_count == 0 || value <= shadow_minima[minima_count-1]) begin
               shadow_minima[minima_count] = value;
               minima_count++;
            end
         end
      end else begin
         if (value_count == 0) begin
            view.status = ST_UNDERFLOW;
         end else begin
            if (minima_count > 0 &&
                shadow_minima[minima_count-1] == shadow_values[value_count-1])
               minima_count--;
            value_count--;
         end
      end
      view.top = (value_count > 0) ? shadow_values[value_count-1] : '0;
      view.min = (value_count > 0 && minima_count > 0) ? shadow_minima[minima_count-1] : '0;
      view.occupancy = OccupancyWidth'(value_count);
      return view;
   endfunction

   function automatic logic signed [PortValueWidth-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2, 3, 4: return $signed($urandom_range(0, 15)) - 8;
         default: return $signed($urandom);
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(op_type op, logic signed [PortValueWidth-1:0] value);
      start          <= 1'b1;
      req_type       <= op;
      req_push_value <= value;
      do @(posedge clock); while (busy);
      expected_views = {expected_views, apply_stack_op(op, value)};
      @(negedge clock);
   endtask

   task automatic maybe_idle();
      int gap;
      if (idling_on && $urandom_range(0, 99) < 13) begin
         gap = $urandom_range(1, 2);
         start          <= 1'b0;
         req_type       <= 1'($urandom);
         req_push_value <= $urandom;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (expected_views.size() != 0) @(negedge clock);
   endtask

   task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 10)
         $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_views.size() == 0) begin
            note_mismatch("unexpected word", '0, rsp_top_value);
         end else begin
            oldest_view = expected_views.pop_front();
            if (rsp_top_value !== oldest_view.top)
               note_mismatch("top", oldest_view.top, rsp_top_value);
            if (rsp_min_value !== oldest_view.min)
               note_mismatch("min", oldest_view.min, rsp_min_value);
            if (rsp_occupancy !== oldest_view.occupancy)
               note_mismatch("occupancy", 32'(oldest_view.occupancy), 32'(rsp_occupancy));
            if (rsp_status !== oldest_view.status)
               note_mismatch("status", 32'(oldest_view.status), 32'(rsp_status));
         end
      end
   end

   task automatic test_pop_empty();
      send_word(OP_POP, 32'sh1234_5678);
      send_word(OP_POP, -1);
   endtask

   task automatic test_extremes();
      send_word(OP_PUSH, 32'sh7FFF_FFFF);
      send_word(OP_PUSH, 32'sh7FFF_FFFF);
      send_word(OP_PUSH, 0);
      send_word(OP_PUSH, 5);
      send_word(OP_PUSH, 32'sh8000_0000);
      send_word(OP_PUSH, -1);
      send_word(OP_PUSH, 32'sh8000_0000);
      send_word(OP_PUSH, 32'sh8000_0001);
      send_word(OP_POP, 0);
      send_word(OP_POP, 0);
      send_word(OP_POP, 0);
      send_word(OP_PUSH, 32'sh8000_0000);
      repeat (7) send_word(OP_POP, 32'shFFFF_FFFF);
      send_word(OP_POP, 0);
   endtask

   task automatic test_fill_overflow();
      repeat (Depth) send_word(OP_PUSH, pick_value());
      send_word(OP_PUSH, 32'sh8000_0000);
      send_word(OP_PUSH, 32'sh7FFF_FFFF);
      wait_drained();
      send_word(OP_POP, 0);
      send_word(OP_PUSH, 32'sh8000_0000);
      send_word(OP_PUSH, 1);
      repeat (Depth + 1) send_word(OP_POP, $urandom);
   endtask

   task automatic test_random_words();
      int sent;
      int run_len;
      int push_pct;
      sent = 0;
      while (sent < RandomWords) begin
         run_len = $urandom_range(20, 80);
         if (run_len > RandomWords - sent)
            run_len = RandomWords - sent;
         case ($urandom_range(0, 2))
            0: push_pct = 85;
            1: push_pct = 50;
            default: push_pct = 15;
         endcase
         repeat (run_len) begin
            idling_on = !(sent >= 30 && sent < 80);
            maybe_idle();
            send_word(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP, pick_value());
            sent++;
            if (sent == 90)
               wait_drained();
         end
      end
   endtask

   initial begin
      int drain_cycles;
      errors         = 0;
      value_count    = 0;
      minima_count   = 0;
      idling_on      = 1'b0;
      reset          = 1'b1;
      start          = 1'b0;
      req_type       = 1'b0;
      req_push_value = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_pop_empty();
      test_extremes();
      wait_drained();
      test_fill_overflow();
      test_random_words();

      start <= 1'b0;
      drain_cycles = 0;
      while (expected_views.size() != 0 && drain_cycles < 1000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (4) @(posedge clock);
      errors += expected_views.size();
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/mss_pkg.sv
rtl/core/mss_mem.sv
rtl/core/min_stack_two_stack_top.sv
test/tb_min_stack_two_stack_top.sv
